// ===== rtl/core/str_pkg.sv =====
package str_pkg;

  localparam int ANGLE_W     = 16;
  localparam int DIST_W      = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int NUM_SECTORS = 5;
  localparam int SECTOR_W    = 3;
  localparam int MEAN_TAPS   = 3;
  localparam int SUM_W       = 19;

  // Truncating divide by three: q = (sum * ceil(2^21 / 3)) >> 21, exact for sum < 2^21.
  localparam int MUL_W      = 20;
  localparam int PROD_W     = SUM_W + MUL_W;
  localparam int DIV3_SHIFT = 21;
  localparam logic [MUL_W-1:0] DIV3_MUL = 20'd699051;

  localparam logic [ANGLE_W-1:0] EDGE_A_RESET = 16'd3000;
  localparam logic [ANGLE_W-1:0] EDGE_B_RESET = 16'd9000;
  localparam logic [ANGLE_W-1:0] EDGE_C_RESET = 16'd15000;
  localparam logic [ANGLE_W-1:0] EDGE_D_RESET = 16'd23000;
  localparam logic [ANGLE_W-1:0] EDGE_E_RESET = 16'd31000;
  localparam logic [DIST_W-1:0]  FILL_RESET   = 17'd100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_A = 3'd0,
    REG_EDGE_B = 3'd1,
    REG_EDGE_C = 3'd2,
    REG_EDGE_D = 3'd3,
    REG_EDGE_E = 3'd4,
    REG_FILL   = 3'd5
  } cfg_idx_e;

  // Per-sector cell control.
  typedef struct packed {
    logic ins;     // insert the sample distance into this sector's list
    logic reload;  // end of scan: load the fill distance into every rank
  } str_ctl_t;

endpackage

// ===== rtl/core/str_rank_cell.sv =====
module str_rank_cell
  import str_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  str_ctl_t          ctl_i,
  input  logic [DIST_W-1:0] fill_i,
  input  logic [DIST_W-1:0] din_i,
  input  logic [DIST_W-1:0] prev_val_i,
  input  logic              prev_lt_i,
  output logic [DIST_W-1:0] val_o,
  output logic              lt_o,
  output logic [DIST_W-1:0] ins_nx_o
);

  logic [DIST_W-1:0] val_q, val_d;
  logic              lt;

  assign lt = din_i < val_q;

  // The upper neighbor taking the sample means every cell below it shifts down by one.
  always_comb begin
    ins_nx_o = val_q;
    if (ctl_i.ins) begin
      if (prev_lt_i) begin
        ins_nx_o = prev_val_i;
      end else if (lt) begin
        ins_nx_o = din_i;
      end
    end
    val_d = ctl_i.reload ? fill_i : ins_nx_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= FILL_RESET;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
  assign lt_o  = lt;

endmodule

// ===== rtl/core/str_sector_chain.sv =====
module str_sector_chain
  import str_pkg::*;
#(
  parameter int DEPTH = 6,
  parameter int TAP   = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  str_ctl_t                         ctl_i,
  input  logic [DIST_W-1:0]                fill_i,
  input  logic [DIST_W-1:0]                din_i,
  output logic [MEAN_TAPS-1:0][DIST_W-1:0] tap_o,
  output logic                             ordered_o
);

  logic [DIST_W-1:0] val    [DEPTH];
  logic [DIST_W-1:0] ins_nx [DEPTH];
  logic              lt     [DEPTH];
  logic [DEPTH-2:0]  ord;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DIST_W-1:0] prev_val;
    logic              prev_lt;
    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_lt  = 1'b0;
    end else begin : g_body
      assign prev_val = val[i-1];
      assign prev_lt  = lt[i-1];
    end

    str_rank_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_i),
      .fill_i     (fill_i),
      .din_i      (din_i),
      .prev_val_i (prev_val),
      .prev_lt_i  (prev_lt),
      .val_o      (val[i]),
      .lt_o       (lt[i]),
      .ins_nx_o   (ins_nx[i])
    );
  end

  for (genvar i = 0; i < DEPTH - 1; i++) begin : g_ord
    assign ord[i] = val[i] <= val[i+1];
  end

  for (genvar k = 0; k < MEAN_TAPS; k++) begin : g_tap
    assign tap_o[k] = ins_nx[TAP+k];
  end

  assign ordered_o = &ord;

endmodule

// ===== rtl/core/str_mean_div3.sv =====
module str_mean_div3
  import str_pkg::*;
(
  input  logic                             clk_i,
  input  logic [MEAN_TAPS-1:0][DIST_W-1:0] tap_i,
  input  logic                             sum_en_i,
  input  logic                             quo_en_i,
  output logic [DIST_W-1:0]                mean_o
);

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] mean_q;

  assign sum_d = SUM_W'(tap_i[0]) + SUM_W'(tap_i[1]) + SUM_W'(tap_i[2]);
  assign prod  = PROD_W'(sum_q) * PROD_W'(DIV3_MUL);

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      sum_q <= sum_d;
    end
    if (quo_en_i) begin
      mean_q <= prod[DIV3_SHIFT +: DIST_W];
    end
  end

  assign mean_o = mean_q;

endmodule

// ===== rtl/core/sector_trimmed_nearest_range.sv =====
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: angle, distance; tlast: scan end
// m_axis    out  m_axis_tvalid/tready      tdata: sector 0..4 trimmed mean ranges
// cfg       in   cfg_we_i (no wait)        cfg_index_i, cfg_wdata_i
//
// One sample request is taken per clock while s_axis_tready_o is high; the rank cells register it.
// A scan result passes the tap capture, sum and reciprocal multiply registers, in that order.
// Reset loads every rank cell with the reset fill distance and the edges with their defaults.
// A stalled output holds the three-stage result pipeline; input stalls only when it is full.
module sector_trimmed_nearest_range
  import str_pkg::*;
#(
  parameter int SKIP_COUNT = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [15:0] angle_centideg, [32:16] distance_mm, [39:33] zero
  input  logic [39:0]           s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [16:0] sector0_range, [33:17] sector1_range, [50:34] sector2_range,
  // [67:51] sector3_range, [84:68] sector4_range, [87:85] zero
  output logic [87:0]           m_axis_tdata_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int RANK_DEPTH = SKIP_COUNT + 3;

  // Configuration registers. Writes must come only while the block is idle; it is not enforced.
  logic [ANGLE_W-1:0] edge_a_q, edge_b_q, edge_c_q, edge_d_q, edge_e_q;
  logic [DIST_W-1:0]  fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_a_q <= EDGE_A_RESET;
      edge_b_q <= EDGE_B_RESET;
      edge_c_q <= EDGE_C_RESET;
      edge_d_q <= EDGE_D_RESET;
      edge_e_q <= EDGE_E_RESET;
      fill_q   <= FILL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_EDGE_A: edge_a_q <= cfg_wdata_i[ANGLE_W-1:0];
        REG_EDGE_B: edge_b_q <= cfg_wdata_i[ANGLE_W-1:0];
        REG_EDGE_C: edge_c_q <= cfg_wdata_i[ANGLE_W-1:0];
        REG_EDGE_D: edge_d_q <= cfg_wdata_i[ANGLE_W-1:0];
        REG_EDGE_E: edge_e_q <= cfg_wdata_i[ANGLE_W-1:0];
        REG_FILL:   fill_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input unpacking and the accept strobe.
  logic [ANGLE_W-1:0] angle;
  logic [DIST_W-1:0]  dist_mm;
  logic               s_acc;
  logic               scan_done;

  assign angle     = s_axis_tdata_i[ANGLE_W-1:0];
  assign dist_mm   = s_axis_tdata_i[ANGLE_W +: DIST_W];
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign scan_done = s_acc && s_axis_tlast_i;

  // Sector choice, tested in priority order. The wrap sector covers the span from
  // edge E through zero up to edge A; everything else that is left goes to sector 4.
  logic [SECTOR_W-1:0] sel;

  always_comb begin
    if (angle >= edge_b_q && angle < edge_c_q) begin
      sel = 3'd0;
    end else if (angle >= edge_c_q && angle < edge_d_q) begin
      sel = 3'd1;
    end else if (angle >= edge_d_q && angle < edge_e_q) begin
      sel = 3'd2;
    end else if (angle >= edge_e_q || angle < edge_a_q) begin
      sel = 3'd3;
    end else begin
      sel = 3'd4;
    end
  end

  // One chain of rank cells per sector. A zero distance never enters a list, but a
  // zero-distance last sample still closes the scan and reloads every list.
  logic [NUM_SECTORS-1:0][MEAN_TAPS-1:0][DIST_W-1:0] tap;
  logic [NUM_SECTORS-1:0]                            ordered;
  logic [NUM_SECTORS-1:0][MEAN_TAPS-1:0][DIST_W-1:0] tap_q;

  for (genvar s = 0; s < NUM_SECTORS; s++) begin : g_sector
    str_ctl_t ctl;
    assign ctl.ins    = s_acc && (dist_mm != '0) && (sel == SECTOR_W'(s));
    assign ctl.reload = scan_done;

    str_sector_chain #(
      .DEPTH (RANK_DEPTH),
      .TAP   (SKIP_COUNT)
    ) u_chain (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .fill_i    (fill_q),
      .din_i     (dist_mm),
      .tap_o     (tap[s]),
      .ordered_o (ordered[s])
    );
  end

  // Result pipeline: stage 1 holds the three ranks that follow the SKIP_COUNT nearest in each
  // sector as they stand after the last insertion, stage 2 their sums, stage 3 the quotients by three.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic adv12, adv23;

  assign rdy3  = !v3_q || m_axis_tready_i;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign adv12 = v1_q && rdy2;
  assign adv23 = v2_q && rdy3;

  assign s_axis_tready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= scan_done || (v1_q && !rdy2);
      v2_q <= adv12 || (v2_q && !rdy3);
      v3_q <= adv23 || (v3_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_done) begin
      tap_q <= tap;
    end
  end

  logic [NUM_SECTORS-1:0][DIST_W-1:0] mean;

  for (genvar s = 0; s < NUM_SECTORS; s++) begin : g_mean
    str_mean_div3 u_div (
      .clk_i    (clk_i),
      .tap_i    (tap_q[s]),
      .sum_en_i (adv12),
      .quo_en_i (adv23),
      .mean_o   (mean[s])
    );
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {3'b000, mean};

  // The end of a scan always lands in the first result stage.
  a_scan_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |=> v1_q)
    else $error("scan end did not load the result pipeline");

  // Every rank list stays in ascending order.
  a_lists_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &ordered)
    else $error("rank list out of order");

  // A sum waiting in stage 2 with stage 3 free moves on in the next cycle.
  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !v3_q) |=> v3_q)
    else $error("result pipeline failed to advance");

  // Input is held off only while every result stage is occupied.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v1_q && v2_q && v3_q && !m_axis_tready_i))
    else $error("input stalled with room in the pipeline");

endmodule
